/* sv/leg_deflection_hold_detector_assert.svh */
// Assertion macros for the hold detector checker.
// Each expects clk in the scope where it is used; those that are off in reset also expect rst_n.
`ifndef LEG_DEFLECTION_HOLD_DETECTOR_ASSERT_SVH
`define LEG_DEFLECTION_HOLD_DETECTOR_ASSERT_SVH

// Same-cycle implication, off while in reset.
`define LHD_CHK_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define LHD_CHK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define LHD_CHK_NEXT_ALWAYS(name, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/lhd_pkg.sv */
package lhd_pkg;

  localparam int POS_W      = 13;  // sole position, 1/16 mm
  localparam int OFFSET_W   = 14;  // measured minus command (left), command minus measured (right)
  localparam int MS_W       = 16;
  localparam int BALL_W     = 15;
  localparam int DIST_W     = 14;
  localparam int LEG_OFF_W  = 13;
  localparam int SQ_W       = 29;  // one squared ball coordinate
  localparam int DIST_SQ_W  = 30;  // sum of two squares
  localparam int LIM_SQ_W   = 28;  // squared distance limit
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [MS_W-1:0]      MIN_MS_RST     = 16'd100;
  localparam logic [MS_W-1:0]      MAX_MS_RST     = 16'd1000;
  localparam logic [DIST_W-1:0]    MAX_DIST_RST   = 14'd1000;
  localparam logic [LEG_OFF_W-1:0] MIN_OFFSET_RST = 13'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_MS     = 2'd0,
    REG_MAX_MS     = 2'd1,
    REG_MAX_DIST   = 2'd2,
    REG_MIN_OFFSET = 2'd3
  } cfg_reg_t;

  // Per-item buffer control: clr empties, adv shifts one entry in.
  typedef struct packed {
    logic clr;
    logic adv;
  } buf_ctrl_t;

endpackage

/* sv/lhd_cmd_delay.sv */
module lhd_cmd_delay #(
  parameter int DELAY_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lhd_pkg::buf_ctrl_t               ctrl,
  input  logic signed [lhd_pkg::POS_W-1:0] cmd_in,
  output logic signed [lhd_pkg::POS_W-1:0] cmd_old
);

  // cmd_old is the command from DELAY_DEPTH-1 items back (current one at depth 1)
  if (DELAY_DEPTH == 1) begin : g_direct
    assign cmd_old = cmd_in;
  end else begin : g_line
    logic signed [lhd_pkg::POS_W-1:0] dly_r [DELAY_DEPTH-1];

    always_ff @(posedge clk) begin
      if (!rst_n || ctrl.clr) begin
        for (int i = 0; i < DELAY_DEPTH - 1; i++) dly_r[i] <= '0;
      end else if (ctrl.adv) begin
        dly_r[0] <= cmd_in;
        for (int i = 1; i < DELAY_DEPTH - 1; i++) dly_r[i] <= dly_r[i-1];
      end
    end

    assign cmd_old = dly_r[DELAY_DEPTH-2];
  end

endmodule

/* sv/lhd_offset_window.sv */
module lhd_offset_window #(
  parameter int AVG_WINDOW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lhd_pkg::buf_ctrl_t                  ctrl,
  input  logic signed [lhd_pkg::OFFSET_W-1:0] diff_in,
  output logic signed [lhd_pkg::OFFSET_W+$clog2(AVG_WINDOW)-1:0] sum_r
);

  localparam int SUM_W = lhd_pkg::OFFSET_W + $clog2(AVG_WINDOW);

  // Unfilled slots hold zero, so dropping the oldest entry is exact.
  logic signed [lhd_pkg::OFFSET_W-1:0] win_r [AVG_WINDOW];
  logic signed [SUM_W-1:0]             sum_nxt;

  assign sum_nxt = sum_r + SUM_W'(diff_in) - SUM_W'(win_r[AVG_WINDOW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clr) begin
      for (int i = 0; i < AVG_WINDOW; i++) win_r[i] <= '0;
      sum_r <= '0;
    end else if (ctrl.adv) begin
      win_r[0] <= diff_in;
      for (int i = 1; i < AVG_WINDOW; i++) win_r[i] <= win_r[i-1];
      sum_r <= sum_nxt;
    end
  end

endmodule

/* sv/leg_deflection_hold_detector.sv */
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  upright, playing, 4 sole positions, ball time/pos
// out      output     out_valid/out_stall ball_holding
// cfg      input      cfg_wr_en          cfg_index, cfg_wdata
//
// Three stage pipeline: input register, buffer update + squaring, compare into
// the result register. One item per cycle while the output is not stalled.
// Delay lines, windows and sums are updated as an item leaves the input
// register. rst_n is synchronous and clears control, fill counts, delay lines,
// windows and sums, and loads register defaults. A stalled output freezes only
// the stages that are full; up to two more items are taken while a result waits.
module leg_deflection_hold_detector #(
  parameter int DELAY_DEPTH = 8,
  parameter int AVG_WINDOW  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_robot_upright,
  input  logic                                 in_game_playing,
  input  logic signed [lhd_pkg::POS_W-1:0]     in_commanded_left_y,
  input  logic signed [lhd_pkg::POS_W-1:0]     in_commanded_right_y,
  input  logic signed [lhd_pkg::POS_W-1:0]     in_measured_left_y,
  input  logic signed [lhd_pkg::POS_W-1:0]     in_measured_right_y,
  input  logic        [lhd_pkg::MS_W-1:0]      in_ms_since_ball_seen,
  input  logic signed [lhd_pkg::BALL_W-1:0]    in_ball_rel_x,
  input  logic signed [lhd_pkg::BALL_W-1:0]    in_ball_rel_y,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_ball_holding,
  // configuration
  input  logic                                 cfg_wr_en,
  input  logic        [lhd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [lhd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = lhd_pkg::OFFSET_W + $clog2(AVG_WINDOW);
  localparam int DF_W  = $clog2(DELAY_DEPTH + 1);
  localparam int WF_W  = $clog2(AVG_WINDOW + 1);

  // ---------------- configuration registers ----------------
  logic [lhd_pkg::MS_W-1:0]      min_ms_r, max_ms_r;
  logic [lhd_pkg::DIST_W-1:0]    max_dist_r;
  logic [lhd_pkg::LEG_OFF_W-1:0] min_offset_r;
  logic [lhd_pkg::LIM_SQ_W-1:0]  lim_sq_r;   // max_dist squared
  logic [SUM_W-1:0]              thresh_r;   // min_offset * window size

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ms_r     <= lhd_pkg::MIN_MS_RST;
      max_ms_r     <= lhd_pkg::MAX_MS_RST;
      max_dist_r   <= lhd_pkg::MAX_DIST_RST;
      min_offset_r <= lhd_pkg::MIN_OFFSET_RST;
    end else if (cfg_wr_en) begin
      case (lhd_pkg::cfg_reg_t'(cfg_index))
        lhd_pkg::REG_MIN_MS:     min_ms_r     <= cfg_wdata[lhd_pkg::MS_W-1:0];
        lhd_pkg::REG_MAX_MS:     max_ms_r     <= cfg_wdata[lhd_pkg::MS_W-1:0];
        lhd_pkg::REG_MAX_DIST:   max_dist_r   <= cfg_wdata[lhd_pkg::DIST_W-1:0];
        lhd_pkg::REG_MIN_OFFSET: min_offset_r <= cfg_wdata[lhd_pkg::LEG_OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived limits follow the registers in the next cycle; items pass the input
  // and stage-2 registers before the compare, so a write at idle is always seen.
  always_ff @(posedge clk) begin
    lim_sq_r <= {{(lhd_pkg::LIM_SQ_W-lhd_pkg::DIST_W){1'b0}}, max_dist_r}
              * {{(lhd_pkg::LIM_SQ_W-lhd_pkg::DIST_W){1'b0}}, max_dist_r};
    thresh_r <= SUM_W'(min_offset_r) * SUM_W'(AVG_WINDOW);
  end

  // ---------------- pipeline flow ----------------
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  logic adv1;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign adv1     = v1_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic                                up_r, play_r;
  logic signed [lhd_pkg::POS_W-1:0]    cmd_l_r, cmd_r_r, meas_l_r, meas_r_r;
  logic        [lhd_pkg::MS_W-1:0]     ms_r;
  logic signed [lhd_pkg::BALL_W-1:0]   bx_r, by_r;

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      up_r     <= in_robot_upright;
      play_r   <= in_game_playing;
      cmd_l_r  <= in_commanded_left_y;
      cmd_r_r  <= in_commanded_right_y;
      meas_l_r <= in_measured_left_y;
      meas_r_r <= in_measured_right_y;
      ms_r     <= in_ms_since_ball_seen;
      bx_r     <= in_ball_rel_x;
      by_r     <= in_ball_rel_y;
    end
  end

  // ---------------- stage 1 -> 2: buffer update ----------------
  logic [DF_W-1:0] dfill_r;
  logic [WF_W-1:0] wfill_r;
  logic            dly_full_new, win_full_new;
  lhd_pkg::buf_ctrl_t dly_ctrl, win_ctrl;

  // fill counts after this item's write
  assign dly_full_new = dfill_r >= DF_W'(DELAY_DEPTH - 1);
  assign win_full_new = wfill_r >= WF_W'(AVG_WINDOW - 1);

  assign dly_ctrl.clr = adv1 && !up_r;
  assign dly_ctrl.adv = adv1 && up_r;
  assign win_ctrl.clr = adv1 && !up_r;
  assign win_ctrl.adv = adv1 && up_r && dly_full_new;

  always_ff @(posedge clk) begin
    if (!rst_n || dly_ctrl.clr) begin
      dfill_r <= '0;
      wfill_r <= '0;
    end else begin
      if (dly_ctrl.adv && dfill_r != DF_W'(DELAY_DEPTH)) dfill_r <= dfill_r + 1'b1;
      if (win_ctrl.adv && wfill_r != WF_W'(AVG_WINDOW))  wfill_r <= wfill_r + 1'b1;
    end
  end

  logic signed [lhd_pkg::POS_W-1:0]    old_l, old_r;
  logic signed [lhd_pkg::OFFSET_W-1:0] diff_l, diff_r;
  logic signed [SUM_W-1:0]             sum_l, sum_r;

  lhd_cmd_delay #(.DELAY_DEPTH(DELAY_DEPTH)) u_dly_l (
    .clk, .rst_n, .ctrl(dly_ctrl), .cmd_in(cmd_l_r), .cmd_old(old_l)
  );
  lhd_cmd_delay #(.DELAY_DEPTH(DELAY_DEPTH)) u_dly_r (
    .clk, .rst_n, .ctrl(dly_ctrl), .cmd_in(cmd_r_r), .cmd_old(old_r)
  );

  // left: measured minus command; right: command minus measured
  assign diff_l = lhd_pkg::OFFSET_W'(meas_l_r) - lhd_pkg::OFFSET_W'(old_l);
  assign diff_r = lhd_pkg::OFFSET_W'(old_r) - lhd_pkg::OFFSET_W'(meas_r_r);

  // Sums reflect the item in stage 2: nothing advances while stage 2 holds.
  lhd_offset_window #(.AVG_WINDOW(AVG_WINDOW)) u_win_l (
    .clk, .rst_n, .ctrl(win_ctrl), .diff_in(diff_l), .sum_r(sum_l)
  );
  lhd_offset_window #(.AVG_WINDOW(AVG_WINDOW)) u_win_r (
    .clk, .rst_n, .ctrl(win_ctrl), .diff_in(diff_r), .sum_r(sum_r)
  );

  // ball squares and the cheap gate terms
  logic signed [2*lhd_pkg::BALL_W-1:0] bx_sq, by_sq;
  logic [lhd_pkg::SQ_W-1:0]            bx_sq_r, by_sq_r;
  logic                                gate_nxt, gate_r;

  assign bx_sq    = bx_r * bx_r;
  assign by_sq    = by_r * by_r;
  assign gate_nxt = up_r && dly_full_new && win_full_new && play_r
                 && (ms_r > min_ms_r) && (ms_r < max_ms_r);

  always_ff @(posedge clk) begin
    if (adv1) begin
      bx_sq_r <= bx_sq[lhd_pkg::SQ_W-1:0];
      by_sq_r <= by_sq[lhd_pkg::SQ_W-1:0];
      gate_r  <= gate_nxt;
    end
  end

  // ---------------- stage 2 -> 3: compares ----------------
  logic [lhd_pkg::DIST_SQ_W-1:0] dist_sq;
  logic                          hold_nxt, hold_r;

  assign dist_sq  = lhd_pkg::DIST_SQ_W'(bx_sq_r) + lhd_pkg::DIST_SQ_W'(by_sq_r);
  assign hold_nxt = gate_r
                 && (dist_sq < lhd_pkg::DIST_SQ_W'(lim_sq_r))
                 && (sum_l > $signed(thresh_r))
                 && (sum_r > $signed(thresh_r));

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) hold_r <= hold_nxt;
  end

  assign out_valid        = v3_r;
  assign out_ball_holding = hold_r;

endmodule

/* sv/lhd_port_checker.sv */
`include "leg_deflection_hold_detector_assert.svh"

module lhd_port_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic                                  out_ball_holding
);

  // reset empties the pipeline
  `LHD_CHK_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid, "result valid after reset")

  // input backs up only behind a waiting, stalled result
  `LHD_CHK_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")

  // a stalled result stays put
  `LHD_CHK_NEXT(a_out_hold, out_valid && out_stall,
                out_valid && $stable(out_ball_holding), "stalled result changed")

endmodule

bind leg_deflection_hold_detector lhd_port_checker u_lhd_port_checker (.*);

/* tb/sv/tb_leg_deflection_hold_detector.sv */
module tb_leg_deflection_hold_detector;

  localparam int DELAY_DEPTH    = 8;
  localparam int AVG_WINDOW     = 8;
  localparam int SUM_W          = lhd_pkg::OFFSET_W + 3;  // 8-entry window of 14-bit deviations
  localparam int POS_MAX        = (1 << (lhd_pkg::POS_W - 1)) - 1;
  localparam int POS_MIN        = -(1 << (lhd_pkg::POS_W - 1));
  localparam int WATCHDOG_LIMIT = 2000;          // cycles with no item moving on either side
  localparam int DRAIN_CYCLES   = 8;             // pipeline is three deep
  localparam int SETTLE_CYCLES  = 4;
  localparam int IDLE_PCT       = 21;

  // One sensor frame as the block sees it.
  typedef struct {
    logic                              upright;
    logic                              playing;
    logic signed [lhd_pkg::POS_W-1:0]  cmd_l;
    logic signed [lhd_pkg::POS_W-1:0]  cmd_r;
    logic signed [lhd_pkg::POS_W-1:0]  meas_l;
    logic signed [lhd_pkg::POS_W-1:0]  meas_r;
    logic [lhd_pkg::MS_W-1:0]          ms;
    logic signed [lhd_pkg::BALL_W-1:0] ball_x;
    logic signed [lhd_pkg::BALL_W-1:0] ball_y;
  } frame_t;

  // ---------------------------------------------------------------- DUT pins
  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic                              in_robot_upright = 1'b0;
  logic                              in_game_playing = 1'b0;
  logic signed [lhd_pkg::POS_W-1:0]  in_commanded_left_y = '0;
  logic signed [lhd_pkg::POS_W-1:0]  in_commanded_right_y = '0;
  logic signed [lhd_pkg::POS_W-1:0]  in_measured_left_y = '0;
  logic signed [lhd_pkg::POS_W-1:0]  in_measured_right_y = '0;
  logic [lhd_pkg::MS_W-1:0]          in_ms_since_ball_seen = '0;
  logic signed [lhd_pkg::BALL_W-1:0] in_ball_rel_x = '0;
  logic signed [lhd_pkg::BALL_W-1:0] in_ball_rel_y = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic                              out_ball_holding;
  logic                              cfg_wr_en = 1'b0;
  logic [lhd_pkg::CFG_IDX_W-1:0]     cfg_index = lhd_pkg::REG_MIN_MS;
  logic [lhd_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

  leg_deflection_hold_detector #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .AVG_WINDOW (AVG_WINDOW)
  ) uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_robot_upright     (in_robot_upright),
    .in_game_playing      (in_game_playing),
    .in_commanded_left_y  (in_commanded_left_y),
    .in_commanded_right_y (in_commanded_right_y),
    .in_measured_left_y   (in_measured_left_y),
    .in_measured_right_y  (in_measured_right_y),
    .in_ms_since_ball_seen(in_ms_since_ball_seen),
    .in_ball_rel_x        (in_ball_rel_x),
    .in_ball_rel_y        (in_ball_rel_y),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_ball_holding     (out_ball_holding),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ------------------------------------------------------ predictor state
  // Shadow of the config registers, loaded with the reset defaults.
  logic [lhd_pkg::MS_W-1:0]       hold_min_ms   = lhd_pkg::MIN_MS_RST;
  logic [lhd_pkg::MS_W-1:0]       hold_max_ms   = lhd_pkg::MAX_MS_RST;
  logic [lhd_pkg::DIST_W-1:0]     hold_max_dist = lhd_pkg::MAX_DIST_RST;
  logic [lhd_pkg::LEG_OFF_W-1:0]  hold_min_off  = lhd_pkg::MIN_OFFSET_RST;

  // Command history per leg (circular), deviation windows and their sums.
  logic signed [lhd_pkg::POS_W-1:0]    cmd_hist_l [DELAY_DEPTH];
  logic signed [lhd_pkg::POS_W-1:0]    cmd_hist_r [DELAY_DEPTH];
  int unsigned                         hist_pos, hist_fill;
  logic signed [lhd_pkg::OFFSET_W-1:0] dev_win_l [AVG_WINDOW];
  logic signed [lhd_pkg::OFFSET_W-1:0] dev_win_r [AVG_WINDOW];
  int unsigned                         win_pos, win_fill;
  logic signed [SUM_W-1:0]             dev_sum_l, dev_sum_r;

  bit expected_holding[$];  // one holding flag per accepted frame, oldest first
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit gaps_on = 1'b1;       // sender inserts random bubbles
  bit stalls_on = 1'b1;     // receiver stalls at random

  function automatic void clear_history();
    for (int i = 0; i < DELAY_DEPTH; i++) begin
      cmd_hist_l[i] = '0;
      cmd_hist_r[i] = '0;
    end
    for (int i = 0; i < AVG_WINDOW; i++) begin
      dev_win_l[i] = '0;
      dev_win_r[i] = '0;
    end
    hist_pos  = 0;
    hist_fill = 0;
    win_pos   = 0;
    win_fill  = 0;
    dev_sum_l = '0;
    dev_sum_r = '0;
  endfunction

  // Advance the shadow state by one frame and return the holding flag it yields.
  function automatic bit predict_holding(input frame_t f);
    int     dev_l, dev_r, thresh;
    longint dist_sq, lim_sq;
    if (!f.upright) begin
      clear_history();
      return 1'b0;
    end
    cmd_hist_l[hist_pos] = f.cmd_l;
    cmd_hist_r[hist_pos] = f.cmd_r;
    hist_pos = (hist_pos + 1) % DELAY_DEPTH;
    if (hist_fill < DELAY_DEPTH) hist_fill++;
    if (hist_fill < DELAY_DEPTH) return 1'b0;

    // slot after the newest write holds the oldest command
    dev_l = int'(f.meas_l) - int'(cmd_hist_l[hist_pos]);
    dev_r = int'(cmd_hist_r[hist_pos]) - int'(f.meas_r);
    dev_sum_l = SUM_W'(int'(dev_sum_l) + dev_l - int'(dev_win_l[win_pos]));
    dev_sum_r = SUM_W'(int'(dev_sum_r) + dev_r - int'(dev_win_r[win_pos]));
    dev_win_l[win_pos] = lhd_pkg::OFFSET_W'(dev_l);
    dev_win_r[win_pos] = lhd_pkg::OFFSET_W'(dev_r);
    win_pos = (win_pos + 1) % AVG_WINDOW;
    if (win_fill < AVG_WINDOW) win_fill++;
    if (win_fill < AVG_WINDOW) return 1'b0;

    dist_sq = longint'(f.ball_x) * longint'(f.ball_x) + longint'(f.ball_y) * longint'(f.ball_y);
    lim_sq  = longint'(hold_max_dist) * longint'(hold_max_dist);
    // sum > offset * window is the exact form of average > offset
    thresh  = int'(hold_min_off) * AVG_WINDOW;
    if (f.ms > hold_min_ms && f.ms < hold_max_ms && dist_sq < lim_sq && f.playing)
      return (int'(dev_sum_l) > thresh) && (int'(dev_sum_r) > thresh);
    return 1'b0;
  endfunction

  // ---------------------------------------------------------- stimulus helpers
  function automatic int rand_between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic logic signed [lhd_pkg::POS_W-1:0] clamp_pos(input int v);
    if (v > POS_MAX) return lhd_pkg::POS_W'(POS_MAX);
    if (v < POS_MIN) return lhd_pkg::POS_W'(POS_MIN);
    return lhd_pkg::POS_W'(v);
  endfunction

  function automatic frame_t mk(input bit up, input bit pl, input int cl, input int cr,
                                input int ml, input int mr, input int ms,
                                input int bx, input int by);
    frame_t f;
    f.upright = up;
    f.playing = pl;
    f.cmd_l   = lhd_pkg::POS_W'(cl);
    f.cmd_r   = lhd_pkg::POS_W'(cr);
    f.meas_l  = lhd_pkg::POS_W'(ml);
    f.meas_r  = lhd_pkg::POS_W'(mr);
    f.ms      = lhd_pkg::MS_W'(ms);
    f.ball_x  = lhd_pkg::BALL_W'(bx);
    f.ball_y  = lhd_pkg::BALL_W'(by);
    return f;
  endfunction

  // Fully random frame: exercises every bit, mostly breaks the hold sequence.
  function automatic frame_t noise_frame();
    frame_t f;
    f.upright = 1'($urandom_range(1));
    f.playing = 1'($urandom_range(1));
    f.cmd_l   = lhd_pkg::POS_W'($urandom);
    f.cmd_r   = lhd_pkg::POS_W'($urandom);
    f.meas_l  = lhd_pkg::POS_W'($urandom);
    f.meas_r  = lhd_pkg::POS_W'($urandom);
    f.ms      = lhd_pkg::MS_W'($urandom);
    f.ball_x  = lhd_pkg::BALL_W'($urandom);
    f.ball_y  = lhd_pkg::BALL_W'($urandom);
    return f;
  endfunction

  // Frame that tends to satisfy the current settings: steady commands, legs
  // pushed apart around the threshold, ball close and inside the time band.
  function automatic frame_t hold_frame(input int base_l, input int base_r);
    frame_t f;
    int     cl, cr, off_l, off_r, roll, reach;
    f.upright = ($urandom_range(99) >= 2);
    f.playing = ($urandom_range(99) >= 5);
    cl = base_l;
    cr = base_r;
    if ($urandom_range(99) < 25) begin
      cl += rand_between(-2, 2);
      cr += rand_between(-2, 2);
    end
    off_l = int'(hold_min_off) + rand_between(-6, 20);
    off_r = int'(hold_min_off) + rand_between(-6, 20);
    f.cmd_l  = clamp_pos(cl);
    f.cmd_r  = clamp_pos(cr);
    f.meas_l = clamp_pos(cl + off_l);
    f.meas_r = clamp_pos(cr - off_r);

    roll = $urandom_range(99);
    if (int'(hold_max_ms) > int'(hold_min_ms) + 1 && roll >= 10)
      f.ms = lhd_pkg::MS_W'(rand_between(int'(hold_min_ms) + 1, int'(hold_max_ms) - 1));
    else if (roll < 5)
      f.ms = hold_min_ms;  // band edges are exclusive
    else if (roll < 10)
      f.ms = hold_max_ms;
    else
      f.ms = lhd_pkg::MS_W'($urandom);

    roll  = $urandom_range(99);
    reach = int'(hold_max_dist) * 7 / 10;
    if (roll < 6) begin
      f.ball_x = lhd_pkg::BALL_W'(int'(hold_max_dist));  // exactly on the limit: not close
      f.ball_y = '0;
    end else if (roll < 10) begin
      f.ball_x = '0;
      f.ball_y = lhd_pkg::BALL_W'(1 - int'(hold_max_dist));
    end else begin
      f.ball_x = lhd_pkg::BALL_W'(rand_between(-reach, reach));
      f.ball_y = lhd_pkg::BALL_W'(rand_between(-reach, reach));
    end
    return f;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Starts and ends just after a falling edge. Holds the item until taken.
  task automatic send_frame(input frame_t f);
    if (gaps_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid              <= 1'b1;
    in_robot_upright      <= f.upright;
    in_game_playing       <= f.playing;
    in_commanded_left_y   <= f.cmd_l;
    in_commanded_right_y  <= f.cmd_r;
    in_measured_left_y    <= f.meas_l;
    in_measured_right_y   <= f.meas_r;
    in_ms_since_ball_seen <= f.ms;
    in_ball_rel_x         <= f.ball_x;
    in_ball_rel_y         <= f.ball_y;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_holding.push_back(predict_holding(f));
    @(negedge clk);
  endtask

  // Block is quiet once every result is out and the pipe has settled.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_holding.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all four registers back to back; upper data bits are discarded
  // by the block for the narrower registers.
  task automatic write_registers(input logic [lhd_pkg::CFG_DATA_W-1:0] min_ms,
                                 input logic [lhd_pkg::CFG_DATA_W-1:0] max_ms,
                                 input logic [lhd_pkg::CFG_DATA_W-1:0] max_dist,
                                 input logic [lhd_pkg::CFG_DATA_W-1:0] min_off);
    cfg_wr_en <= 1'b1;
    cfg_index <= lhd_pkg::REG_MIN_MS;
    cfg_wdata <= min_ms;
    @(negedge clk);
    cfg_index <= lhd_pkg::REG_MAX_MS;
    cfg_wdata <= max_ms;
    @(negedge clk);
    cfg_index <= lhd_pkg::REG_MAX_DIST;
    cfg_wdata <= max_dist;
    @(negedge clk);
    cfg_index <= lhd_pkg::REG_MIN_OFFSET;
    cfg_wdata <= min_off;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    hold_min_ms   = min_ms;
    hold_max_ms   = max_ms;
    hold_max_dist = max_dist[lhd_pkg::DIST_W-1:0];
    hold_min_off  = min_off[lhd_pkg::LEG_OFF_W-1:0];
  endtask

  // Mostly hold-style episodes with random content, some noise bursts.
  task automatic run_random_phase(input int n_items);
    int sent, len, base_l, base_r;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        len    = rand_between(12, 60);
        base_l = rand_between(-1000, 1000);
        base_r = rand_between(-1000, 1000);
        repeat (len) begin
          send_frame(hold_frame(base_l, base_r));
          sent++;
        end
      end else begin
        len = rand_between(1, 8);
        repeat (len) begin
          send_frame(noise_frame());
          sent++;
        end
      end
    end
  endtask

  // ------------------------------------------------------------------ tests
  // Reset defaults: clear on fall, delay fill, window fill, hold, each gate.
  task automatic test_directed_sequence();
    // not upright, every field at an extreme
    send_frame(mk(0, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 65535, -16384, 16383));
    // largest deviation on both legs; first 14 fill the buffers, then hold
    repeat (16) send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, 0, 0));
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 100, 0, 0));   // ms on low edge
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 1000, 0, 0));  // ms on high edge
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, 1000, 0)); // ball on limit
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 101, 999, 0));
    send_frame(mk(1, 0, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 999, 0, -999)); // not playing
    send_frame(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));                              // fall clears
    send_frame(mk(1, 1, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 0, -16384, -16384));
  endtask

  // Window sums at both ends of their range against the largest thresholds.
  task automatic test_sum_extremes();
    wait_idle();
    write_registers(16'd0, 16'hFFFF, 16'h3FFF, 16'd8190);
    send_frame(mk(0, 1, 0, 0, 0, 0, 500, 0, 0));
    repeat (16) send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, 100, 100));
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, -16384, 0));
    send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, 16382, 0));
    wait_idle();
    // threshold now equals the largest reachable sum
    write_registers(16'd0, 16'hFFFF, 16'h3FFF, 16'h1FFF);
    repeat (3) send_frame(mk(1, 1, POS_MIN, POS_MAX, POS_MAX, POS_MIN, 500, 0, 0));
    // most negative deviation on both legs
    repeat (16) send_frame(mk(1, 1, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 500, 0, 0));
  endtask

  // Empty time band, zero distance and zero offset, then the widest settings.
  task automatic test_register_extremes();
    wait_idle();
    write_registers(16'hFFFF, 16'd0, 16'd0, 16'd0);
    run_random_phase(40);
    wait_idle();
    write_registers(16'd0, 16'hFFFF, 16'hFFFF, 16'hE000);  // upper bits dropped
    run_random_phase(80);
  endtask

  task automatic test_random_traffic();
    int lo_ms;
    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      // middle phase runs with neither bubbles nor stalls
      gaps_on   = (phase != 2);
      stalls_on = (phase != 2);
      lo_ms = rand_between(0, 600);
      write_registers(lhd_pkg::CFG_DATA_W'(lo_ms),
                      lhd_pkg::CFG_DATA_W'(lo_ms + rand_between(2, 3000)),
                      {2'($urandom), 14'(rand_between(50, 16383))},
                      {3'($urandom), 13'(rand_between(0, 300))});
      run_random_phase(100);
    end
  endtask

  // ------------------------------------------------------- result side
  always @(negedge clk) begin
    out_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk) begin : check_result
    bit want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_holding.size() == 0) begin
        report_mismatch("result with no item waiting");
      end else begin
        want = expected_holding.pop_front();
        if (out_ball_holding !== want)
          report_mismatch($sformatf("ball_holding got %b want %b", out_ball_holding, want));
      end
    end
  end

  // Ends a run that stops moving items.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR at %0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    clear_history();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_sequence();
    test_sum_extremes();
    test_register_extremes();
    test_random_traffic();
    in_valid <= 1'b0;
    while (expected_holding.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
